// ----- hdl/aff2i_pkg.sv -----
// ----------------------------------------------------------------------------
// Affine 2D inverse package
// Widths, limits and pipeline record types shared by the inverse datapath.
// ----------------------------------------------------------------------------
package aff2i_pkg;

  // Fraction bits of the signed fixed-point coefficient format.
  localparam int FRAC_BITS = 16;
  // Numerator width: a 64-bit product magnitude shifted by the fraction bits.
  localparam int NumW = 64 + FRAC_BITS;
  // Quotient bits resolved by the divider; anything larger is an overflow.
  localparam int QBits = 33;
  // Number of quotients formed for every transform.
  localparam int Lanes = 6;
  // Pipeline depth: four front stages, the divider steps, rounding, output.
  localparam int NumStages = 6 + QBits;

  // Reset value of the tolerance shift.
  localparam logic [5:0] ShiftReset = 6'd40;

  // Largest magnitudes that still fit a signed 32-bit result.
  localparam logic [QBits:0] PosLimit = (QBits + 1)'(32'h7FFF_FFFF);
  localparam logic [QBits:0] NegLimit = (QBits + 1)'(32'h8000_0000);

  // After the multipliers.
  typedef struct packed {
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] a3;
    logic signed [63:0] p03;
    logic signed [63:0] p21;
    logic signed [63:0] p25;
    logic signed [63:0] p34;
    logic signed [63:0] p14;
    logic signed [63:0] p05;
    logic        [31:0] basis;
  } aff2i_mul_t;

  // After the product differences and the basis square.
  typedef struct packed {
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] a3;
    logic signed [64:0] det;
    logic signed [64:0] n4;
    logic signed [64:0] n5;
    logic        [63:0] b2;
  } aff2i_diff_t;

  // Unsigned numerators and divisor with result signs.
  typedef struct packed {
    logic [Lanes-1:0][NumW-1:0] num;
    logic [Lanes-1:0]           neg;
    logic [63:0]                dmag;
    logic [63:0]                b2;
  } aff2i_num_t;

  // One quotient lane inside the divider.
  typedef struct packed {
    logic [63:0]      rem;
    logic [QBits-1:0] low;
    logic [QBits-1:0] quo;
    logic             neg;
    logic             ovf;
  } aff2i_lane_t;

  // One transform inside the divider.
  typedef struct packed {
    aff2i_lane_t [Lanes-1:0] lane;
    logic [63:0]             dmag;
    logic                    sing;
  } aff2i_div_t;

  // Rounded magnitudes before the range check.
  typedef struct packed {
    logic [Lanes-1:0][QBits:0] res;
    logic [Lanes-1:0]          neg;
    logic [Lanes-1:0]          ovf;
    logic                      sing;
  } aff2i_rnd_t;

endpackage

// ----- hdl/affine_2d_inverse.sv -----
// ----------------------------------------------------------------------------
// Affine 2D inverse
// Pipelined inverse of a fixed-point 2D affine transform with singularity
// and overflow detection.
// ----------------------------------------------------------------------------
// Usage:
// A transform enters on the input channel (six coefficients) with valid_i;
// it is transferred at a rising edge where valid_i is high and stall_o low.
// The inverse leaves on the output channel with valid_o and is transferred
// where valid_o is high and stall_i low. The block is a 39-stage pipeline:
// multipliers, product differences, magnitudes, the singularity test, one
// restoring divider step per quotient bit (33 steps), rounding and the
// output register. One transform is taken every cycle while stall_o is low;
// when the receiver stalls, the output register holds and empty stages
// further up keep filling, so stall_o only rises once the pipeline is full.
// Reset empties every stage and sets the tolerance shift to 40. cfg_we_i
// writes a new shift; the user must do so only while the block is idle, as
// the block does not enforce it. A singular transform, or one whose inverse
// overflows, gives invertible_o low with all coefficient outputs zero.
// ----------------------------------------------------------------------------
module affine_2d_inverse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] col0_x_i,
  input  logic signed [31:0] col0_y_i,
  input  logic signed [31:0] col1_x_i,
  input  logic signed [31:0] col1_y_i,
  input  logic signed [31:0] offset_x_i,
  input  logic signed [31:0] offset_y_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] inv_col0_x_o,
  output logic signed [31:0] inv_col0_y_o,
  output logic signed [31:0] inv_col1_x_o,
  output logic signed [31:0] inv_col1_y_o,
  output logic signed [31:0] inv_offset_x_o,
  output logic signed [31:0] inv_offset_y_o,
  output logic               invertible_o
);

  localparam int NS = aff2i_pkg::NumStages;
  localparam int QB = aff2i_pkg::QBits;
  localparam int NW = aff2i_pkg::NumW;
  localparam int LN = aff2i_pkg::Lanes;
  localparam int FB = aff2i_pkg::FRAC_BITS;

  // Magnitude of a signed 32-bit coefficient.
  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    return a[31] ? 32'(-a) : a;
  endfunction

  // Magnitude of a signed 65-bit difference.
  function automatic logic [63:0] mag65(input logic signed [64:0] a);
    logic [64:0] n;
    n = -a;
    return a[64] ? n[63:0] : a[63:0];
  endfunction

  // One restoring division step on a lane.
  function automatic aff2i_pkg::aff2i_lane_t div_step(input aff2i_pkg::aff2i_lane_t l,
                                                      input logic [63:0] d);
    aff2i_pkg::aff2i_lane_t o;
    logic [64:0]            t;
    logic [64:0]            s;
    logic                   ge;
    o  = l;
    t  = {l.rem, l.low[QB-1]};
    ge = t >= {1'b0, d};
    s  = t - {1'b0, d};
    o.rem = ge ? s[63:0] : t[63:0];
    o.low = {l.low[QB-2:0], 1'b0};
    o.quo = {l.quo[QB-2:0], ge};
    return o;
  endfunction

  logic [5:0] shift_q;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_d;
  logic [NS-1:0] adv;

  aff2i_pkg::aff2i_mul_t  mul_q;
  aff2i_pkg::aff2i_diff_t diff_q;
  aff2i_pkg::aff2i_num_t  num_q;
  aff2i_pkg::aff2i_div_t  div_q [QB+1];
  aff2i_pkg::aff2i_rnd_t  rnd_q;

  logic [LN-1:0][31:0] res_q;
  logic                inv_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= aff2i_pkg::ShiftReset;
    end else if (cfg_we_i) begin
      shift_q <= cfg_wdata_i;
    end
  end

  // Stage advance chain: a stage loads when it is empty or its successor moves.
  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || !stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) begin
        vld_d[k] = (k == 0) ? valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign stall_o = !adv[0];
  assign valid_o = vld_q[NS-1];

  // Stage 1: the six products and the basis.
  always_ff @(posedge clk_i) begin
    logic [31:0] m0, m1, m2, m3, mx01, mx23;
    m0   = mag32(col0_x_i);
    m1   = mag32(col0_y_i);
    m2   = mag32(col1_x_i);
    m3   = mag32(col1_y_i);
    mx01 = (m0 > m1) ? m0 : m1;
    mx23 = (m2 > m3) ? m2 : m3;
    if (adv[0]) begin
      mul_q.a0    <= col0_x_i;
      mul_q.a1    <= col0_y_i;
      mul_q.a2    <= col1_x_i;
      mul_q.a3    <= col1_y_i;
      mul_q.p03   <= 64'(col0_x_i) * 64'(col1_y_i);
      mul_q.p21   <= 64'(col1_x_i) * 64'(col0_y_i);
      mul_q.p25   <= 64'(col1_x_i) * 64'(offset_y_i);
      mul_q.p34   <= 64'(col1_y_i) * 64'(offset_x_i);
      mul_q.p14   <= 64'(col0_y_i) * 64'(offset_x_i);
      mul_q.p05   <= 64'(col0_x_i) * 64'(offset_y_i);
      mul_q.basis <= (mx01 > mx23) ? mx01 : mx23;
    end
  end

  // Stage 2: determinant, translation numerators and the basis square.
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      diff_q.a0  <= mul_q.a0;
      diff_q.a1  <= mul_q.a1;
      diff_q.a2  <= mul_q.a2;
      diff_q.a3  <= mul_q.a3;
      diff_q.det <= 65'(mul_q.p03) - 65'(mul_q.p21);
      diff_q.n4  <= 65'(mul_q.p25) - 65'(mul_q.p34);
      diff_q.n5  <= 65'(mul_q.p14) - 65'(mul_q.p05);
      diff_q.b2  <= 64'(mul_q.basis) * 64'(mul_q.basis);
    end
  end

  // Stage 3: unsigned numerators scaled into the output format, and signs.
  always_ff @(posedge clk_i) begin
    logic dneg;
    dneg = diff_q.det[64];
    if (adv[2]) begin
      num_q.num[0] <= NW'(mag32(diff_q.a3)) << (2 * FB);
      num_q.num[1] <= NW'(mag32(diff_q.a1)) << (2 * FB);
      num_q.num[2] <= NW'(mag32(diff_q.a2)) << (2 * FB);
      num_q.num[3] <= NW'(mag32(diff_q.a0)) << (2 * FB);
      num_q.num[4] <= NW'(mag65(diff_q.n4)) << FB;
      num_q.num[5] <= NW'(mag65(diff_q.n5)) << FB;
      num_q.neg[0] <= diff_q.a3[31] ^ dneg;
      num_q.neg[1] <= (diff_q.a1 > 0) ^ dneg;
      num_q.neg[2] <= (diff_q.a2 > 0) ^ dneg;
      num_q.neg[3] <= diff_q.a0[31] ^ dneg;
      num_q.neg[4] <= diff_q.n4[64] ^ dneg;
      num_q.neg[5] <= diff_q.n5[64] ^ dneg;
      num_q.dmag   <= mag65(diff_q.det);
      num_q.b2     <= diff_q.b2;
    end
  end

  // Stage 4: singularity test and divider set-up with the early overflow check.
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      div_q[0].dmag <= num_q.dmag;
      div_q[0].sing <= num_q.dmag <= (num_q.b2 >> shift_q);
      for (int i = 0; i < LN; i++) begin
        div_q[0].lane[i].rem <= 64'(num_q.num[i][NW-1:QB]);
        div_q[0].lane[i].low <= num_q.num[i][QB-1:0];
        div_q[0].lane[i].quo <= '0;
        div_q[0].lane[i].neg <= num_q.neg[i];
        div_q[0].lane[i].ovf <= 64'(num_q.num[i][NW-1:QB]) >= num_q.dmag;
      end
    end
  end

  // Divider: one quotient bit per stage in every lane.
  for (genvar j = 1; j <= QB; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv[3+j]) begin
        div_q[j].dmag <= div_q[j-1].dmag;
        div_q[j].sing <= div_q[j-1].sing;
        for (int i = 0; i < LN; i++) begin
          div_q[j].lane[i] <= div_step(div_q[j-1].lane[i], div_q[j-1].dmag);
        end
      end
    end
  end

  // Rounding to nearest, ties away from zero.
  always_ff @(posedge clk_i) begin
    if (adv[NS-2]) begin
      rnd_q.sing <= div_q[QB].sing;
      for (int i = 0; i < LN; i++) begin
        rnd_q.res[i] <= {1'b0, div_q[QB].lane[i].quo} +
                        (QB + 1)'({div_q[QB].lane[i].rem, 1'b0} >= {1'b0, div_q[QB].dmag});
        rnd_q.neg[i] <= div_q[QB].lane[i].neg;
        rnd_q.ovf[i] <= div_q[QB].lane[i].ovf;
      end
    end
  end

  // Output register: range check, sign and zeroing of failed transforms.
  always_ff @(posedge clk_i) begin
    logic [LN-1:0]      ok;
    logic [LN-1:0][QB:0] nr;
    for (int i = 0; i < LN; i++) begin
      nr[i] = ~rnd_q.res[i] + 1'b1;
      ok[i] = !rnd_q.ovf[i] &&
              (rnd_q.neg[i] ? (rnd_q.res[i] <= aff2i_pkg::NegLimit)
                            : (rnd_q.res[i] <= aff2i_pkg::PosLimit));
    end
    if (adv[NS-1]) begin
      inv_q <= !rnd_q.sing && (&ok);
      for (int i = 0; i < LN; i++) begin
        if (!rnd_q.sing && (&ok)) begin
          res_q[i] <= rnd_q.neg[i] ? nr[i][31:0] : rnd_q.res[i][31:0];
        end else begin
          res_q[i] <= '0;
        end
      end
    end
  end

  assign inv_col0_x_o   = res_q[0];
  assign inv_col0_y_o   = res_q[1];
  assign inv_col1_x_o   = res_q[2];
  assign inv_col1_y_o   = res_q[3];
  assign inv_offset_x_o = res_q[4];
  assign inv_offset_y_o = res_q[5];
  assign invertible_o   = inv_q;

endmodule
